// ----- rtl/dsrp_pkg.sv -----
// Shared types and constants for the dense set with random pick.
`default_nettype none

package dsrp_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int VALUE_W      = 32;
	localparam int DRAW_W       = 31;
	localparam int STEP_W       = $clog2(DRAW_W);
	localparam int COUNT_W      = 9;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_PICK   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_REJECTED = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    scan_start;
		logic    div_start;
		logic    rd_last;
		logic    rd_pick;
		logic    wr_append;
		logic    wr_move;
		logic    respond;
		status_t status;
		logic    pick_out;
	} dsrp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic scan_fin;
		logic found;
		logic div_fin;
		logic cnt_zero;
		logic cnt_full;
	} dsrp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/dsrp_ctrl.sv -----
// Controller state machine that sequences insert, remove and pick.
`default_nettype none

module dsrp_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire [1:0]           opcode,
	input  wire dsrp_pkg::dsrp_stat_t st,
	output dsrp_pkg::dsrp_cmd_t  cmd,
	output logic                busy
);
	import dsrp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_RD_LAST,
		S_MOVE,
		S_DIV,
		S_RD_PICK,
		S_PICK_OUT
	} state_t;

	state_t state_q;
	state_t state_d;
	op_t    op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_INSERT;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				op_q <= op_t'(opcode);
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.load = start;
				if (start) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (op_q)
					OP_INSERT, OP_REMOVE: begin
						cmd.scan_start = 1'b1;
						state_d        = S_SCAN;
					end
					OP_PICK: begin
						if (st.cnt_zero) begin
							cmd.respond = 1'b1;
							cmd.status  = ST_EMPTY;
							state_d     = S_IDLE;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end
					end
					default: begin
						cmd.respond = 1'b1;
						cmd.status  = ST_REJECTED;
						state_d     = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (st.scan_fin) begin
					if (op_q == OP_INSERT) begin
						cmd.respond = 1'b1;
						state_d     = S_IDLE;
						// A duplicate is reported before a full set.
						if (st.found) begin
							cmd.status = ST_REJECTED;
						end else if (st.cnt_full) begin
							cmd.status = ST_FULL;
						end else begin
							cmd.wr_append = 1'b1;
							cmd.status    = ST_DONE;
						end
					end else if (st.found) begin
						state_d = S_RD_LAST;
					end else begin
						cmd.respond = 1'b1;
						cmd.status  = ST_REJECTED;
						state_d     = S_IDLE;
					end
				end
			end
			S_RD_LAST: begin
				cmd.rd_last = 1'b1;
				state_d     = S_MOVE;
			end
			S_MOVE: begin
				cmd.wr_move = 1'b1;
				cmd.respond = 1'b1;
				cmd.status  = ST_DONE;
				state_d     = S_IDLE;
			end
			S_DIV: begin
				if (st.div_fin) begin
					state_d = S_RD_PICK;
				end
			end
			S_RD_PICK: begin
				cmd.rd_pick = 1'b1;
				state_d     = S_PICK_OUT;
			end
			S_PICK_OUT: begin
				cmd.respond  = 1'b1;
				cmd.status   = ST_DONE;
				cmd.pick_out = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/dsrp_datapath.sv -----
// Datapath: element memory, count, linear scan, remainder unit and result registers.
`default_nettype none

module dsrp_datapath #(
	parameter int CAPACITY = dsrp_pkg::CAPACITY_DEF
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire signed [dsrp_pkg::VALUE_W-1:0]    value,
	input  wire        [dsrp_pkg::DRAW_W-1:0]     random_draw,
	input  wire dsrp_pkg::dsrp_cmd_t              cmd,
	output dsrp_pkg::dsrp_stat_t                  st,
	output logic                                  done,
	output logic       [1:0]                      status,
	output logic signed [dsrp_pkg::VALUE_W-1:0]   picked_value,
	output logic       [dsrp_pkg::COUNT_W-1:0]    element_count
);
	import dsrp_pkg::*;

	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [VALUE_W-1:0] mem [CAPACITY];
	logic [VALUE_W-1:0] rdata_q;
	logic [AW-1:0]      rd_addr;

	logic [VALUE_W-1:0] value_q;
	logic [DRAW_W-1:0]  draw_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cnt_d;
	logic [CNT_W-1:0]   last_idx;

	// Scan engine.
	logic               scan_busy_q;
	logic               scan_fin_q;
	logic               found_q;
	logic [AW-1:0]      slot_q;
	logic [CNT_W-1:0]   idx_q;
	logic               pend_s1;
	logic [AW-1:0]      pend_idx_s1;
	logic               issue;
	logic               hit;

	// Remainder unit.
	logic               div_busy_q;
	logic               div_fin_q;
	logic [CNT_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [CNT_W:0]     trial;
	logic [CNT_W:0]     diff;

	// Result registers.
	logic               done_q;
	status_t            status_q;
	logic [VALUE_W-1:0] picked_q;
	logic [COUNT_W-1:0] out_count_q;

	assign last_idx = cnt_q - CNT_W'(1);
	assign issue    = scan_busy_q && (idx_q < cnt_q) && !hit;
	assign hit      = pend_s1 && (rdata_q == value_q);
	assign trial    = {rem_q, draw_q[DRAW_W-1]};
	assign diff     = trial - {1'b0, cnt_q};

	always_comb begin
		if (cmd.rd_last) begin
			rd_addr = last_idx[AW-1:0];
		end else if (cmd.rd_pick) begin
			rd_addr = rem_q[AW-1:0];
		end else begin
			rd_addr = idx_q[AW-1:0];
		end
	end

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.wr_append) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (cmd.wr_move) begin
			cnt_d = last_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_append) begin
			mem[cnt_q[AW-1:0]] <= value_q;
		end else if (cmd.wr_move) begin
			// The last element, read in S_RD_LAST, fills the hole.
			mem[slot_q] <= rdata_q;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
			draw_q  <= random_draw;
		end else if (div_busy_q) begin
			draw_q <= {draw_q[DRAW_W-2:0], 1'b0};
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end else if (div_busy_q) begin
			rem_q <= diff[CNT_W] ? trial[CNT_W-1:0] : diff[CNT_W-1:0];
		end
		if (hit) begin
			slot_q <= pend_idx_s1;
		end
		pend_idx_s1 <= idx_q[AW-1:0];
		if (cmd.respond) begin
			status_q    <= cmd.status;
			picked_q    <= cmd.pick_out ? rdata_q : '0;
			out_count_q <= COUNT_W'(cnt_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			scan_busy_q <= 1'b0;
			scan_fin_q  <= 1'b0;
			found_q     <= 1'b0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			div_busy_q  <= 1'b0;
			div_fin_q   <= 1'b0;
			step_q      <= '0;
			done_q      <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			done_q <= cmd.respond;

			if (cmd.scan_start) begin
				scan_busy_q <= 1'b1;
				scan_fin_q  <= 1'b0;
				found_q     <= 1'b0;
				idx_q       <= '0;
				pend_s1     <= 1'b0;
			end else if (scan_busy_q) begin
				pend_s1 <= issue;
				if (issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (hit) begin
					scan_busy_q <= 1'b0;
					scan_fin_q  <= 1'b1;
					found_q     <= 1'b1;
				end else if (!issue && !pend_s1) begin
					scan_busy_q <= 1'b0;
					scan_fin_q  <= 1'b1;
				end
			end

			if (cmd.div_start) begin
				div_busy_q <= 1'b1;
				div_fin_q  <= 1'b0;
				step_q     <= STEP_W'(DRAW_W - 1);
			end else if (div_busy_q) begin
				if (step_q == '0) begin
					div_busy_q <= 1'b0;
					div_fin_q  <= 1'b1;
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	assign st.scan_fin = scan_fin_q;
	assign st.found    = found_q;
	assign st.div_fin  = div_fin_q;
	assign st.cnt_zero = (cnt_q == '0);
	assign st.cnt_full = (cnt_q == CNT_W'(CAPACITY));

	assign done          = done_q;
	assign status        = status_q;
	assign picked_value  = picked_q;
	assign element_count = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("element count above capacity");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(scan_fin_q) && found_q |-> slot_q < cnt_q[AW-1:0] || cnt_q == CNT_W'(CAPACITY))
		else $error("matched slot outside the occupied range");

	a_rem_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_fin_q) |-> rem_q < cnt_q)
		else $error("pick remainder not below the count");

	a_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q != ST_DONE |-> picked_q == '0)
		else $error("picked value nonzero on a failed transaction");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// ----- rtl/dense_set_with_random_pick.sv -----
// Top level of the dense set with insert, remove and random pick.
//
//   channel   signals                                   direction  handshake
//   command   start, opcode, value, random_draw          in         start && !busy
//   result    done, status, picked_value, element_count  out        done, one cycle
//
// Insert and remove scan the occupied slots one per cycle through the single
// memory read port. Pick runs a 31-step restoring remainder unit; other
// opcodes and a pick on an empty set are answered without a scan or division.
// Reset clears the count and all control state; the element memory is not
// cleared, since only slots below the count are ever used.
// A result shows for exactly one cycle on done; the receiver cannot stall it,
// and a new command may be started in the cycle the result is shown.
`default_nettype none

module dense_set_with_random_pick #(
	parameter int CAPACITY = dsrp_pkg::CAPACITY_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire        [1:0]                    opcode,
	input  wire signed [dsrp_pkg::VALUE_W-1:0]  value,
	input  wire        [dsrp_pkg::DRAW_W-1:0]   random_draw,
	output logic                                done,
	output logic       [1:0]                    status,
	output logic signed [dsrp_pkg::VALUE_W-1:0] picked_value,
	output logic       [dsrp_pkg::COUNT_W-1:0]  element_count
);
	import dsrp_pkg::*;

	dsrp_cmd_t  cmd;
	dsrp_stat_t st;

	dsrp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	dsrp_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.value         (value),
		.random_draw   (random_draw),
		.cmd           (cmd),
		.st            (st),
		.done          (done),
		.status        (status),
		.picked_value  (picked_value),
		.element_count (element_count)
	);

endmodule

`default_nettype wire

// ----- bench/dense_set_with_random_pick_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the dense set with insert, remove and random pick.

module dense_set_with_random_pick_tb;

	import dsrp_pkg::*;

	localparam int          SET_CAP    = CAPACITY_DEF;
	localparam int          RAND_ITEMS = 2000;
	localparam int          IDLE_PCT   = 37;
	localparam int          LIMIT      = 3_000_000;
	localparam logic [1:0]  OP_UNUSED  = 2'd3;
	localparam logic [30:0] DRAW_MAX   = 31'h7fff_ffff;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] val;
		logic [30:0] draw;
	} set_cmd_t;

	typedef struct {
		status_t            status;
		logic signed [31:0] picked;
		logic [8:0]         count;
	} set_result_t;

	typedef enum {GEN_GROW, GEN_SHRINK, GEN_MIXED} gen_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [1:0]                  opcode = '0;
	logic signed [VALUE_W-1:0]   value = '0;
	logic [DRAW_W-1:0]           random_draw = '0;
	logic                        done;
	logic [1:0]                  status;
	logic signed [VALUE_W-1:0]   picked_value;
	logic [COUNT_W-1:0]          element_count;

	set_cmd_t    pend_q[$];
	set_result_t exp_q[$];
	logic [31:0] gen_set[$];
	logic [31:0] mdl_store[SET_CAP];
	int          mdl_count = 0;
	int          err_cnt = 0;
	int          res_cnt = 0;
	int          sent_cnt = 0;
	int          cycle_cnt = 0;
	logic        taken = 1'b0;

	dense_set_with_random_pick dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.value        (value),
		.random_draw  (random_draw),
		.done         (done),
		.status       (status),
		.picked_value (picked_value),
		.element_count(element_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		$display("MISMATCH result %0d, %s: expected %0h, got %0h", res_cnt, what, want, got);
		err_cnt++;
	endtask

	function automatic int set_find(logic [31:0] v);
		for (int i = 0; i < mdl_count; i++)
			if (mdl_store[i] == v)
				return i;
		return -1;
	endfunction

	// Applies one command to the shadow set and returns what the block must answer.
	function automatic set_result_t set_apply(set_cmd_t c);
		set_result_t r;
		int          slot;
		r.status = ST_REJECTED;
		r.picked = '0;
		slot = set_find(c.val);
		case (c.op)
			OP_INSERT: begin
				if (slot >= 0)
					r.status = ST_REJECTED;
				else if (mdl_count >= SET_CAP)
					r.status = ST_FULL;
				else begin
					mdl_store[mdl_count] = c.val;
					mdl_count++;
					r.status = ST_DONE;
				end
			end
			OP_REMOVE: begin
				if (slot >= 0) begin
					mdl_store[slot] = mdl_store[mdl_count - 1];
					mdl_count--;
					r.status = ST_DONE;
				end
			end
			OP_PICK: begin
				if (mdl_count == 0)
					r.status = ST_EMPTY;
				else begin
					r.picked = mdl_store[int'(c.draw) % mdl_count];
					r.status = ST_DONE;
				end
			end
			default: ;
		endcase
		r.count = mdl_count[8:0];
		return r;
	endfunction

	// The stimulus side keeps its own membership list so that it can aim
	// removes and duplicate inserts at values that are really held.
	task automatic queue_cmd(logic [1:0] op, logic [31:0] v, logic [30:0] d);
		set_cmd_t c;
		int       idx[$];
		c.op = op;
		c.val = v;
		c.draw = d;
		pend_q.insert(pend_q.size(), c);
		idx = gen_set.find_first_index with (item == v);
		if (op == OP_INSERT && idx.size() == 0 && gen_set.size() < SET_CAP)
			gen_set.insert(gen_set.size(), v);
		else if (op == OP_REMOVE && idx.size() != 0)
			gen_set.delete(idx[0]);
	endtask

	function automatic logic [31:0] fresh_value();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [30:0] rand_draw();
		case ($urandom_range(7))
			0: return '0;
			1: return DRAW_MAX;
			2: return 31'($urandom_range(511));
			default: return 31'($urandom());
		endcase
	endfunction

	task automatic queue_random(gen_mode_t mode);
		int          t_ins, t_dup, t_rem, t_miss, r;
		logic [31:0] held;
		case (mode)
			GEN_GROW:   begin t_ins = 65; t_dup = 73; t_rem = 83; t_miss = 86; end
			GEN_SHRINK: begin t_ins = 10; t_dup = 15; t_rem = 80; t_miss = 85; end
			default:    begin t_ins = 35; t_dup = 42; t_rem = 72; t_miss = 78; end
		endcase
		r = $urandom_range(99);
		held = (gen_set.size() != 0) ? gen_set[$urandom_range(gen_set.size() - 1)]
			: fresh_value();
		if (r < t_ins)
			queue_cmd(OP_INSERT, fresh_value(), rand_draw());
		else if (r < t_dup)
			queue_cmd(OP_INSERT, held, rand_draw());
		else if (r < t_rem)
			queue_cmd(OP_REMOVE, held, rand_draw());
		else if (r < t_miss)
			queue_cmd(OP_REMOVE, fresh_value(), rand_draw());
		else if (r < 98)
			queue_cmd(OP_PICK, fresh_value(), rand_draw());
		else
			queue_cmd(OP_UNUSED, fresh_value(), rand_draw());
	endtask

	initial begin : stimulus
		int        n_rand;
		int        len;
		gen_mode_t mode;
		queue_cmd(OP_PICK, 32'd0, '0);
		queue_cmd(OP_REMOVE, 32'd5, '0);
		queue_cmd(OP_UNUSED, 32'd0, '0);
		queue_cmd(OP_INSERT, 32'h8000_0000, '0);
		queue_cmd(OP_INSERT, 32'h7fff_ffff, DRAW_MAX);
		queue_cmd(OP_INSERT, 32'h0000_0000, '0);
		queue_cmd(OP_INSERT, 32'hffff_ffff, '0);
		queue_cmd(OP_INSERT, 32'h7fff_ffff, '0);
		queue_cmd(OP_PICK, 32'd0, '0);
		queue_cmd(OP_PICK, 32'hffff_ffff, DRAW_MAX);
		queue_cmd(OP_PICK, 32'd0, 31'd2);
		// Removing a middle element moves the last one into its slot.
		queue_cmd(OP_REMOVE, 32'h0000_0000, '0);
		queue_cmd(OP_REMOVE, 32'h0000_0000, '0);
		queue_cmd(OP_PICK, 32'd0, 31'd1);
		queue_cmd(OP_REMOVE, 32'hffff_ffff, '0);
		queue_cmd(OP_UNUSED, 32'hffff_ffff, DRAW_MAX);
		queue_cmd(OP_REMOVE, 32'h8000_0000, '0);
		queue_cmd(OP_REMOVE, 32'h7fff_ffff, '0);
		queue_cmd(OP_PICK, 32'h5555_5555, DRAW_MAX);
		queue_cmd(OP_INSERT, 32'h5555_5555, 31'h2aaa_aaaa);
		queue_cmd(OP_INSERT, 32'haaaa_aaaa, 31'h5555_5555);
		queue_cmd(OP_PICK, 32'd0, 31'h2aaa_aaaa);
		queue_cmd(OP_REMOVE, 32'haaaa_aaaa, '0);
		queue_cmd(OP_REMOVE, 32'h5555_5555, '0);

		// Fill the set to capacity, then hammer it while full.
		n_rand = 0;
		while (gen_set.size() < SET_CAP) begin
			queue_random(GEN_GROW);
			n_rand++;
		end
		repeat (12) begin
			queue_random(GEN_GROW);
			n_rand++;
		end
		while (n_rand < RAND_ITEMS) begin
			mode = gen_mode_t'($urandom_range(2));
			len = $urandom_range(20, 150);
			repeat (len) begin
				queue_random(mode);
				n_rand++;
			end
		end

		while (pend_q.size() != 0 || start || exp_q.size() != 0)
			@(posedge clk);
		repeat (SET_CAP + 20) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// A command is taken at a rising edge with start high and busy low;
	// another may be put up at the following falling edge.
	always @(negedge clk) begin : drive
		set_cmd_t nxt;
		if (arst_n && (!start || taken)) begin
			if (pend_q.size() != 0 && ((sent_cnt >= 600 && sent_cnt < 900)
					|| $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pend_q.pop_front();
				start <= 1'b1;
				opcode <= nxt.op;
				value <= nxt.val;
				random_draw <= nxt.draw;
				sent_cnt <= sent_cnt + 1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : observe
		set_result_t want;
		set_cmd_t    cur;
		taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (exp_q.size() == 0) begin
					report_mismatch("result with nothing pending", '0, 32'(status));
				end else begin
					want = exp_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(status));
					if (picked_value !== want.picked)
						report_mismatch("picked_value", want.picked, picked_value);
					if (element_count !== want.count)
						report_mismatch("element_count", 32'(want.count),
							32'(element_count));
				end
				res_cnt <= res_cnt + 1;
			end
			if (start && !busy) begin
				cur.op = opcode;
				cur.val = value;
				cur.draw = random_draw;
				exp_q.insert(exp_q.size(), set_apply(cur));
			end
		end
	end

endmodule

// ----- filelist.f -----
rtl/dsrp_pkg.sv
rtl/dsrp_ctrl.sv
rtl/dsrp_datapath.sv
rtl/dense_set_with_random_pick.sv
bench/dense_set_with_random_pick_tb.sv
